### rtl/core/cnra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnra_pkg
// Shared types and constants of the class number allocator: sizes, operation
// and status codes, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package cnra_pkg;

  // table size and count width
  localparam int CLASS_COUNT = 64;
  localparam int COUNT_BITS  = 16;
  localparam int SLOT_W      = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int SCAN_W      = $clog2(CLASS_COUNT + 1);

  // transaction field layout
  localparam int CMD_W       = 2;
  localparam int WORD_W      = 16;
  localparam int NUM_W       = 13;
  localparam int BROWSE_POS  = 14;
  localparam int KEEP_POS    = 13;
  localparam int CLASS_OUT_W = 7;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_RECV  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_ILLEGAL = 3'd2,
    ST_UNALLOC = 3'd3,
    ST_UNDER   = 3'd4,
    ST_OVER    = 3'd5
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture the input transaction
    logic scan_start;  // start the round-robin search at the pointer
    logic scan_next;   // step the search to the next slot
    logic alloc_take;  // current slot is free: allocate it and respond
    logic alloc_fail;  // search exhausted: respond out of classes
    logic clear_resp;  // perform clear and respond
    logic exec_resp;   // perform send or receive update and respond
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic alloc_op;    // transaction needs a search
    logic clear_op;    // transaction is a clear
    logic scan_free;   // slot under search is free
    logic scan_last;   // slot under search is the last one to try
  } dp_stat_t;

endpackage : cnra_pkg
`default_nettype wire

### rtl/core/cnra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnra_ctrl
// Controller state machine: sequences decode, round-robin search and the
// count update, and issues one response command per transaction.
// ----------------------------------------------------------------------------
module cnra_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire cnra_pkg::dp_stat_t   stat,
  output cnra_pkg::ctrl_cmd_t       cmd
);
  import cnra_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
          busy_nxt  = 1'b1;
        end
      end
      S_DECODE: begin
        if (stat.alloc_op) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (stat.clear_op) begin
          cmd.clear_resp = 1'b1;
          state_nxt      = S_IDLE;
          busy_nxt       = 1'b0;
        end else begin
          // table read is in flight, data ready next cycle
          state_nxt = S_EXEC;
        end
      end
      S_SCAN: begin
        if (stat.scan_free) begin
          cmd.alloc_take = 1'b1;
          state_nxt      = S_IDLE;
          busy_nxt       = 1'b0;
        end else if (stat.scan_last) begin
          cmd.alloc_fail = 1'b1;
          state_nxt      = S_IDLE;
          busy_nxt       = 1'b0;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_EXEC: begin
        cmd.exec_resp = 1'b1;
        state_nxt     = S_IDLE;
        busy_nxt      = 1'b0;
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule : cnra_ctrl
`default_nettype wire

### rtl/core/cnra_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnra_dp
// Datapath: use count memory, per-slot allocated flags, search pointer and
// scan registers, count update arithmetic and the registered result.
// ----------------------------------------------------------------------------
module cnra_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [cnra_pkg::CMD_W-1:0]            in_cmd,
  input  wire logic [cnra_pkg::WORD_W-1:0]           in_class_word,
  input  wire logic                                  in_keep_request,
  input  wire cnra_pkg::ctrl_cmd_t                   cmd,
  output cnra_pkg::dp_stat_t                         stat,
  output logic                                       out_valid,
  output logic [cnra_pkg::CLASS_OUT_W-1:0]           out_class_out,
  output logic [cnra_pkg::STATUS_W-1:0]              out_status,
  output logic [cnra_pkg::COUNT_OUT_W-1:0]           out_count_out
);
  import cnra_pkg::*;

  // use count memory; a slot whose allocated flag is clear reads as zero
  logic [COUNT_BITS-1:0]  mem [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] alloc_r;
  logic [COUNT_BITS-1:0]  rdata_r;

  // latched transaction
  cmd_t             op_r;
  logic [NUM_W-1:0] cls_r;
  logic             browse_r;
  logic             keep_r;

  // search state
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [SLOT_W-1:0] scan_slot_r;
  logic [SCAN_W-1:0] scan_left_r;
  logic [SLOT_W-1:0] scan_inc;

  // result registers
  logic                   out_valid_r, out_valid_nxt;
  logic [CLASS_OUT_W-1:0] class_r, class_nxt;
  status_t                status_r, status_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;

  // write controls
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  flag_we;
  logic [SLOT_W-1:0]     flag_addr;
  logic                  flag_val;

  // decode of latched class number
  logic [NUM_W-1:0]      cls_m1;
  logic [SLOT_W-1:0]     cls_slot;
  logic                  cls_zero;
  logic                  cls_legal;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] dec;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [COUNT_BITS+COUNT_OUT_W-1:0] count_ext;

  assign cls_m1    = cls_r - NUM_W'(1);
  assign cls_slot  = cls_m1[SLOT_W-1:0];
  assign cls_zero  = (cls_r == '0);
  assign cls_legal = !cls_zero && (cls_r <= NUM_W'(CLASS_COUNT));
  assign cur       = alloc_r[cls_slot] ? rdata_r : '0;
  assign dec       = cur - COUNT_BITS'(1);
  assign scan_inc  = (scan_slot_r == SLOT_W'(CLASS_COUNT - 1)) ? '0
                                                                : scan_slot_r + SLOT_W'(1);

  // status to the controller
  assign stat.alloc_op  = (op_r == CMD_ALLOC) || ((op_r == CMD_SEND) && cls_zero);
  assign stat.clear_op  = (op_r == CMD_CLEAR);
  assign stat.scan_free = !alloc_r[scan_slot_r];
  assign stat.scan_last = (scan_left_r == SCAN_W'(1));

  // response and table update
  always_comb begin
    out_valid_nxt = 1'b0;
    class_nxt     = class_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    wr_en         = 1'b0;
    wr_addr       = cls_slot;
    wr_data       = '0;
    flag_we       = 1'b0;
    flag_addr     = cls_slot;
    flag_val      = 1'b0;
    new_cnt       = '0;

    if (cmd.alloc_take) begin
      // allocate the found slot; a send adds its use at once
      out_valid_nxt = 1'b1;
      wr_en         = 1'b1;
      wr_addr       = scan_slot_r;
      wr_data       = (op_r == CMD_SEND) ? COUNT_BITS'(2) : COUNT_BITS'(1);
      flag_we       = 1'b1;
      flag_addr     = scan_slot_r;
      flag_val      = 1'b1;
      ptr_nxt       = scan_inc;
      class_nxt     = CLASS_OUT_W'(scan_slot_r) + CLASS_OUT_W'(1);
      status_nxt    = ST_OK;
      count_nxt     = wr_data;
    end else if (cmd.alloc_fail) begin
      out_valid_nxt = 1'b1;
      class_nxt     = '0;
      status_nxt    = ST_FULL;
      count_nxt     = '0;
    end else if (cmd.clear_resp) begin
      out_valid_nxt = 1'b1;
      count_nxt     = '0;
      if (cls_zero) begin
        class_nxt  = '0;
        status_nxt = ST_OK;
      end else if (!cls_legal) begin
        class_nxt  = '0;
        status_nxt = ST_ILLEGAL;
      end else begin
        flag_we    = 1'b1;
        class_nxt  = cls_r[CLASS_OUT_W-1:0];
        status_nxt = ST_OK;
      end
    end else if (cmd.exec_resp) begin
      out_valid_nxt = 1'b1;
      class_nxt     = cls_r[CLASS_OUT_W-1:0];
      if (!cls_legal) begin
        class_nxt  = '0;
        status_nxt = ST_ILLEGAL;
        count_nxt  = '0;
      end else if (cur == '0) begin
        status_nxt = ST_UNALLOC;
        count_nxt  = '0;
      end else if (op_r == CMD_SEND) begin
        if (cur == COUNT_MAX) begin
          status_nxt = ST_OVER;
          count_nxt  = cur;
        end else begin
          wr_en      = 1'b1;
          wr_data    = cur + COUNT_BITS'(1);
          status_nxt = ST_OK;
          count_nxt  = wr_data;
        end
      end else if (browse_r) begin
        status_nxt = ST_OK;
        count_nxt  = cur;
      end else if (cur == COUNT_BITS'(1)) begin
        // decremented too far: class becomes free
        flag_we    = 1'b1;
        status_nxt = ST_UNDER;
        count_nxt  = '0;
      end else begin
        // down to the owner's single use frees the class unless kept
        new_cnt    = ((dec == COUNT_BITS'(1)) && !keep_r) ? '0 : dec;
        wr_en      = 1'b1;
        wr_data    = new_cnt;
        flag_we    = 1'b1;
        flag_val   = (new_cnt != '0);
        status_nxt = ST_OK;
        count_nxt  = new_cnt;
      end
    end
  end

  // count memory: one write port, registered read at the latched slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[cls_slot];
  end

  // transaction capture and search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= cmd_t'(in_cmd);
      cls_r    <= in_class_word[NUM_W-1:0];
      browse_r <= in_class_word[BROWSE_POS];
      keep_r   <= in_keep_request | in_class_word[KEEP_POS];
    end
    if (cmd.scan_start) begin
      scan_slot_r <= ptr_r;
      scan_left_r <= SCAN_W'(CLASS_COUNT);
    end else if (cmd.scan_next) begin
      scan_slot_r <= scan_inc;
      scan_left_r <= scan_left_r - SCAN_W'(1);
    end
    class_r  <= class_nxt;
    status_r <= status_nxt;
    count_r  <= count_nxt;
  end

  // control state: allocated flags, pointer, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (flag_we) begin
        alloc_r[flag_addr] <= flag_val;
      end
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result ports; count reported in its low bits
  assign count_ext     = {{COUNT_OUT_W{1'b0}}, count_r};
  assign out_valid     = out_valid_r;
  assign out_class_out = class_r;
  assign out_status    = status_r;
  assign out_count_out = count_ext[COUNT_OUT_W-1:0];

endmodule : cnra_dp
`default_nettype wire

### rtl/core/class_number_refcount_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// class_number_refcount_allocator_core
// Round-robin class number allocator with per-class use counts.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and each
// transaction returns exactly one result, shown for a single cycle with
// out_valid high; the receiver cannot stall it, so it must take every
// result as it appears. A clear is answered from the decode state, a send on
// a given class or a receive from the exec state that follows the table read.
// An allocate (or a send on class 0) searches the allocated flags one slot
// per cycle from the search pointer and answers at the first free slot; when
// no class is free it tries all CLASS_COUNT slots and reports out of classes.
// The use count memory needs no clearing pass after reset:
// a per-slot allocated flag, cleared by reset, makes a free slot read as
// zero. The next start may be taken in the cycle the result is shown.
// ----------------------------------------------------------------------------
module class_number_refcount_allocator_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [cnra_pkg::CMD_W-1:0]            in_cmd,
  input  wire logic [cnra_pkg::WORD_W-1:0]           in_class_word,
  input  wire logic                                  in_keep_request,
  output logic                                       out_valid,
  output logic [cnra_pkg::CLASS_OUT_W-1:0]           out_class_out,
  output logic [cnra_pkg::STATUS_W-1:0]              out_status,
  output logic [cnra_pkg::COUNT_OUT_W-1:0]           out_count_out
);
  import cnra_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // sequencing
  cnra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (ctrl_cmd)
  );

  // table, search and result
  cnra_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_class_word   (in_class_word),
    .in_keep_request (in_keep_request),
    .cmd             (ctrl_cmd),
    .stat            (dp_stat),
    .out_valid       (out_valid),
    .out_class_out   (out_class_out),
    .out_status      (out_status),
    .out_count_out   (out_count_out)
  );

endmodule : class_number_refcount_allocator_core
`default_nettype wire

### rtl/core/cnra_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnra_checker
// Port-level checks of the allocator core, attached by bind.
// ----------------------------------------------------------------------------
module cnra_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  start,
  input wire logic                                  busy,
  input wire logic                                  out_valid,
  input wire logic [cnra_pkg::CLASS_OUT_W-1:0]      out_class_out,
  input wire logic [cnra_pkg::STATUS_W-1:0]         out_status,
  input wire logic [cnra_pkg::COUNT_OUT_W-1:0]      out_count_out
);
  import cnra_pkg::*;

  // an accepted transaction holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // a result closes its transaction
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while transaction still busy");

  // one single-cycle result per transaction
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held or repeated");

  // out of classes or an illegal number reports no class and no count
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL || out_status == ST_ILLEGAL))
      |-> (out_class_out == '0 && out_count_out == '0))
    else $error("failed transaction reports a class or count");

  // no undefined status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL ||
                   out_status == ST_ILLEGAL || out_status == ST_UNALLOC ||
                   out_status == ST_UNDER || out_status == ST_OVER))
    else $error("undefined status code");

endmodule : cnra_checker

bind class_number_refcount_allocator_core cnra_checker u_cnra_checker (.*);
`default_nettype wire
